### rtl/xoshiro_pkg.sv
// Shared types and constants of the xoshiro256** generator core.
// Used by the controller, the datapath and the top level; depends on nothing.
package xoshiro_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int FRAC_W = 53;
    localparam int NUM_WORDS = 4;
    localparam int WORD_IDX_W = 2;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DRAW,
        OP_MUL,
        OP_SEED,
        OP_MIX_ADD,
        OP_MIX_XOR,
        OP_MIX_END
    } dp_op_t;

    typedef enum logic [1:0] {
        CONST_GAMMA,
        CONST_MIX_A,
        CONST_MIX_B
    } mul_const_t;

    typedef enum logic [1:0] {
        STEP_LOW,
        STEP_CROSS_A,
        STEP_CROSS_B
    } mul_step_t;

    typedef struct packed {
        dp_op_t                  op;
        mul_const_t              csel;
        mul_step_t               step;
        logic [WORD_IDX_W-1:0]   word_idx;
    } dp_cmd_t;

endpackage

### rtl/xoshiro256_random_generator_core.sv
// Top level of the xoshiro256** random generator core with splitmix64 seeding.
// Depends on xoshiro_pkg, xoshiro_ctrl and xoshiro_datapath.
//
// A draw word (kind 1) is accepted in the idle state and its result appears in the
// output register on the next cycle, so draws stream at one per cycle while
// out_ready is high; a new draw is taken while the previous result is being
// handed over. A reseed word (kind 0) gives no result and keeps the block busy:
// each of the nine 64-bit products it needs is built from three 32x32 partial
// products on the one shared multiplier, plus the add and mix steps of the four
// splitmix64 outputs. The seed register may be written at any time the block is
// idle and takes effect at the next reseed.
module xoshiro256_random_generator_core
    import xoshiro_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WORD_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [WORD_W-1:0]   stream_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   random_word,
    output logic [FRAC_W-1:0]   uniform_fraction
);

    dp_cmd_t cmd;

    xoshiro_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    xoshiro_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stream_index     (stream_index),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .random_word      (random_word),
        .uniform_fraction (uniform_fraction)
    );

endmodule

### rtl/xoshiro_datapath.sv
// Datapath of the xoshiro256** core: generator words, seed register, the shared
// 32x32 multiplier that builds 64-bit products, and the output word register.
// Depends on xoshiro_pkg; driven by the commands of xoshiro_ctrl.
module xoshiro_datapath
    import xoshiro_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [WORD_W-1:0]   stream_index,
    input  logic                cfg_we,
    input  logic [WORD_W-1:0]   cfg_wdata,
    output logic [WORD_W-1:0]   random_word,
    output logic [FRAC_W-1:0]   uniform_fraction
);

    logic [WORD_W-1:0] words_reg [NUM_WORDS];
    logic [WORD_W-1:0] words_next [NUM_WORDS];
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] v_reg, v_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] out_reg, out_next;

    logic [WORD_W-1:0] mul_const;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] mul_prod;
    logic [WORD_W-1:0] v_added;
    logic [WORD_W-1:0] times5, times9;
    logic [WORD_W-1:0] t2, t3;

    always_comb
    begin
        case (cmd.csel)
            CONST_GAMMA: mul_const = GOLDEN_GAMMA;
            CONST_MIX_A: mul_const = MIX_MUL_A;
            CONST_MIX_B: mul_const = MIX_MUL_B;
            default:     mul_const = GOLDEN_GAMMA;
        endcase
        case (cmd.step)
            STEP_LOW:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[HALF_W-1:0];
            end
            STEP_CROSS_A:
            begin
                mul_a = z_reg[WORD_W-1:HALF_W];
                mul_b = mul_const[HALF_W-1:0];
            end
            STEP_CROSS_B:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[WORD_W-1:HALF_W];
            end
            default:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[HALF_W-1:0];
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign v_added = v_reg + GOLDEN_GAMMA;
    assign times5 = (words_reg[1] << 2) + words_reg[1];
    assign times9 = ({times5[56:0], times5[63:57]} << 3) + {times5[56:0], times5[63:57]};
    assign t2 = words_reg[2] ^ words_reg[0];
    assign t3 = words_reg[3] ^ words_reg[1];

    always_comb
    begin
        words_next = words_reg;
        v_next = v_reg;
        z_next = z_reg;
        acc_next = acc_reg;
        out_next = out_reg;
        case (cmd.op)
            OP_IDLE:
            begin
            end
            OP_LOAD:
            begin
                z_next = stream_index + 64'd1;
            end
            OP_DRAW:
            begin
                out_next = times9;
                words_next[0] = words_reg[0] ^ t3;
                words_next[1] = words_reg[1] ^ t2;
                words_next[2] = t2 ^ (words_reg[1] << 17);
                words_next[3] = {t3[18:0], t3[63:19]};
            end
            OP_MUL:
            begin
                if (cmd.step == STEP_LOW)
                begin
                    acc_next = mul_prod;
                end
                else
                begin
                    acc_next = acc_reg + {mul_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                end
            end
            OP_SEED:
            begin
                v_next = seed_reg ^ acc_reg;
            end
            OP_MIX_ADD:
            begin
                v_next = v_added;
                z_next = v_added ^ (v_added >> 30);
            end
            OP_MIX_XOR:
            begin
                z_next = acc_reg ^ (acc_reg >> 27);
            end
            OP_MIX_END:
            begin
                words_next[cmd.word_idx] = acc_reg ^ (acc_reg >> 31);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
            seed_reg <= '0;
        end
        else
        begin
            words_reg <= words_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        z_reg <= z_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign random_word = out_reg;
    assign uniform_fraction = out_reg[WORD_W-1:WORD_W-FRAC_W];

endmodule

### rtl/xoshiro_ctrl.sv
// Controller of the xoshiro256** core: handshakes and the reseed sequence.
// Depends on xoshiro_pkg; issues commands to xoshiro_datapath.
module xoshiro_ctrl
    import xoshiro_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    kind,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_MUL,
        S_SEED,
        S_MIX_ADD,
        S_MIX_MUL_A,
        S_MIX_XOR,
        S_MIX_MUL_B,
        S_MIX_END
    } state_t;

    state_t                state_reg, state_next;
    mul_step_t             step_reg, step_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  step_last;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;
    assign step_last = (step_reg == STEP_CROSS_B);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op = OP_IDLE;
        cmd.csel = CONST_GAMMA;
        cmd.step = step_reg;
        cmd.word_idx = word_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = kind ? OP_DRAW : OP_LOAD;
                end
            end
            S_LOAD_MUL:  cmd.op = OP_MUL;
            S_SEED:      cmd.op = OP_SEED;
            S_MIX_ADD:   cmd.op = OP_MIX_ADD;
            S_MIX_MUL_A:
            begin
                cmd.op = OP_MUL;
                cmd.csel = CONST_MIX_A;
            end
            S_MIX_XOR:   cmd.op = OP_MIX_XOR;
            S_MIX_MUL_B:
            begin
                cmd.op = OP_MUL;
                cmd.csel = CONST_MIX_B;
            end
            S_MIX_END:   cmd.op = OP_MIX_END;
            default:     cmd.op = OP_IDLE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        word_next = word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                step_next = STEP_LOW;
                word_next = '0;
                if (accept)
                begin
                    if (kind)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LOAD_MUL;
                    end
                end
            end
            S_LOAD_MUL, S_MIX_MUL_A, S_MIX_MUL_B:
            begin
                case (step_reg)
                    STEP_LOW:     step_next = STEP_CROSS_A;
                    STEP_CROSS_A: step_next = STEP_CROSS_B;
                    default:      step_next = STEP_LOW;
                endcase
                if (step_last)
                begin
                    case (state_reg)
                        S_LOAD_MUL:  state_next = S_SEED;
                        S_MIX_MUL_A: state_next = S_MIX_XOR;
                        default:     state_next = S_MIX_END;
                    endcase
                end
            end
            S_SEED:      state_next = S_MIX_ADD;
            S_MIX_ADD:   state_next = S_MIX_MUL_A;
            S_MIX_XOR:   state_next = S_MIX_MUL_B;
            S_MIX_END:
            begin
                word_next = word_reg + 2'd1;
                if (word_reg == WORD_IDX_W'(NUM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MIX_ADD;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= STEP_LOW;
            word_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            word_reg <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### tb/tb_xoshiro256_random_generator_core.sv
// Self-checking testbench for the xoshiro256** generator core with splitmix64 seeding.
// It drives reseed and draw words under random stalls and checks each result against a predictor.
// Depends on xoshiro_pkg and xoshiro256_random_generator_core.
module tb_xoshiro256_random_generator_core;
    import xoshiro_pkg::*;

    localparam logic KIND_RESEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;
    localparam int SETTLE_CYCLES = 50;
    localparam int MAX_REPORTS = 10;
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         row_kind;
        logic              kind;
        logic [WORD_W-1:0] value;
        logic              typed;
        logic [WORD_W-1:0] typed_word;
    } stim_row_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [FRAC_W-1:0] frac;
    } draw_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [WORD_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic              kind;
    logic [WORD_W-1:0] stream_index;
    logic              out_valid;
    logic              out_ready;
    logic [WORD_W-1:0] random_word;
    logic [FRAC_W-1:0] uniform_fraction;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] gen_words [NUM_WORDS];
    draw_result_t      expected_draws [$];
    draw_result_t      head_draw;
    stim_row_t         directed_rows [$];
    int                mismatch_count;
    int                in_gap_odds;
    int                out_gap_odds;
    int                out_stall_left;

    xoshiro256_random_generator_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .stream_index     (stream_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .random_word      (random_word),
        .uniform_fraction (uniform_fraction)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("xoshiro256_random_generator_core verification failed");
        $finish;
    end

    task automatic reseed_words(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] z;
        int i;
        acc = seed_reg ^ (GOLDEN_GAMMA * (s + 64'd1));
        for (i = 0; i < NUM_WORDS; i++)
        begin
            acc = acc + GOLDEN_GAMMA;
            z = acc;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            gen_words[i] = z ^ (z >> 31);
        end
    endtask

    task automatic step_words(output logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] sh;
        t = gen_words[1] * 64'd5;
        w = {t[56:0], t[63:57]} * 64'd9;
        sh = gen_words[1] << 17;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ sh;
        gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
    endtask

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] exp_val,
                                 input logic [WORD_W-1:0] act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_draws.size() == 0)
                note_mismatch("unexpected word", '0, random_word);
            else
            begin
                head_draw = expected_draws.pop_front();
                if (random_word !== head_draw.word)
                    note_mismatch("random_word", head_draw.word, random_word);
                if (uniform_fraction !== head_draw.frac)
                    note_mismatch("uniform_fraction", {11'd0, head_draw.frac},
                                  {11'd0, uniform_fraction});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || out_gap_odds == 0)
            out_ready <= 1'b1;
        else if (out_stall_left > 0)
        begin
            out_ready <= 1'b0;
            out_stall_left--;
        end
        else if ($urandom_range(0, out_gap_odds - 1) == 0)
        begin
            out_ready <= 1'b0;
            out_stall_left = $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_word(input logic k, input logic [WORD_W-1:0] s, input logic typed,
                             input logic [WORD_W-1:0] typed_word);
        draw_result_t r;
        if (in_gap_odds != 0 && $urandom_range(0, in_gap_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        stream_index <= s;
        do
            @(posedge clk);
        while (!in_ready);
        if (k == KIND_RESEED)
            reseed_words(s);
        else
        begin
            step_words(r.word);
            if (typed)
                r.word = typed_word;
            r.frac = r.word[WORD_W-1:WORD_W-FRAC_W];
            expected_draws.push_back(r);
        end
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] v);
        in_valid <= 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_reg = v;
    endtask

    task automatic add_row(input row_kind_t rk, input logic k, input logic [WORD_W-1:0] v,
                           input logic typed, input logic [WORD_W-1:0] typed_word);
        stim_row_t row;
        row.row_kind = rk;
        row.kind = k;
        row.value = v;
        row.typed = typed;
        row.typed_word = typed_word;
        directed_rows.push_back(row);
    endtask

    function automatic logic [WORD_W-1:0] pick_stream();
        case ($urandom_range(0, 9))
            0: pick_stream = '0;
            1: pick_stream = ALL_ONES;
            2: pick_stream = ALL_ONES - 64'd1;
            3: pick_stream = {32'd0, 24'd0, 8'($urandom)};
            default: pick_stream = {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_random_phase(input int n, input bit allow_idle);
        int i;
        logic k;
        for (i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
            begin
                case (allow_idle ? $urandom_range(0, 2) : 0)
                    0: begin in_gap_odds = 0; out_gap_odds = 0; end
                    1: begin in_gap_odds = 4; out_gap_odds = 4; end
                    default: begin in_gap_odds = 2; out_gap_odds = 3; end
                endcase
            end
            k = (i == 0 || $urandom_range(0, 9) == 0) ? KIND_RESEED : KIND_DRAW;
            send_word(k, pick_stream(), 1'b0, '0);
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        kind = 1'b0;
        stream_index = '0;
        mismatch_count = 0;
        in_gap_odds = 3;
        out_gap_odds = 3;
        out_stall_left = 0;
        seed_reg = '0;
        for (i = 0; i < NUM_WORDS; i++)
            gen_words[i] = '0;

        // Draws before any reseed return zero; the stream index wraps at all ones.
        add_row(ROW_ITEM, KIND_DRAW, ALL_ONES, 1'b1, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b1, '0);
        add_row(ROW_ITEM, KIND_RESEED, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, ALL_ONES, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, ALL_ONES, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_CFG, KIND_DRAW, ALL_ONES, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, ALL_ONES, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, 64'h5555_5555_5555_5555, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_CFG, KIND_DRAW, 64'h8000_0000_0000_0000, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, 64'd1, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_CFG, KIND_DRAW, '0, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, 64'd2, 1'b0, '0);
        add_row(ROW_ITEM, KIND_RESEED, 64'd3, 1'b0, '0);
        add_row(ROW_ITEM, KIND_DRAW, '0, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].row_kind == ROW_CFG)
                write_seed(directed_rows[i].value);
            else
                send_word(directed_rows[i].kind, directed_rows[i].value,
                          directed_rows[i].typed, directed_rows[i].typed_word);
        end

        write_seed({$urandom, $urandom});
        run_random_phase(400, 1'b1);
        write_seed(ALL_ONES);
        run_random_phase(400, 1'b1);
        write_seed('0);
        run_random_phase(300, 1'b1);
        write_seed({$urandom, $urandom});
        run_random_phase(400, 1'b1);
        write_seed({$urandom, $urandom});
        run_random_phase(400, 1'b0);

        in_valid <= 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_draws.size() == 0)
            $display("xoshiro256_random_generator_core verification clean");
        else
            $display("xoshiro256_random_generator_core verification failed");
        $finish;
    end

endmodule
